@@ hw/rtl/word_stream_utf8_hex_text_encoder_macros.svh @@
// Assertion macros shared by the word stream text encoder RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef WORD_STREAM_UTF8_HEX_TEXT_ENCODER_MACROS_SVH
`define WORD_STREAM_UTF8_HEX_TEXT_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every enabled clock edge
`define WSUHE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WSUHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define WSUHE_ASSERT(lbl, clk, rst_n, prop, msg)
`define WSUHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/wsuhe_pkg.sv @@
// Shared types, constants and helpers of the word stream text encoder.
// No dependencies.
`timescale 1ns / 1ps

package wsuhe_pkg;

  localparam int unsigned UNIT_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FILL_W      = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [FILL_W-1:0] FILL_MAX      = 16'hFFFF;
  localparam logic [FILL_W-1:0] MAX_CHUNK_RST = 16'hFFFF;

  localparam logic [UNIT_W-1:0] HEX_LIMIT   = 16'h00FF;
  localparam logic [UNIT_W-1:0] UTF8_2_LIMIT = 16'h07FF;
  localparam logic [BYTE_W-1:0] UTF8_LEAD2   = 8'hC0;
  localparam logic [BYTE_W-1:0] UTF8_LEAD3   = 8'hE0;
  localparam logic [BYTE_W-1:0] UTF8_CONT    = 8'h80;
  localparam logic [5:0]        UTF8_PAYLOAD = 6'h3F;

  // register indexes of the configuration port
  typedef enum logic {
    REG_MAX_CHUNK_BYTES  = 1'b0,
    REG_CHUNKING_ENABLED = 1'b1
  } reg_idx_e;

  typedef enum logic {
    KIND_TEXT      = 1'b0,
    KIND_CHUNK_END = 1'b1
  } kind_e;

  // one classified item: optional chunk end, 2 or 3 text bytes, optional chunk end
  typedef struct packed {
    logic              pre_end;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic              three;
    logic              post_end;
  } cmd_t;

  // uppercase hex character of a nibble
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + ext;
    end else begin
      hex_char = 8'h37 + ext;
    end
  endfunction

endpackage

@@ hw/rtl/wsuhe_front.sv @@
// Front end: config registers, chunk fill tracking and classification of
// each code unit into a command. Depends on wsuhe_pkg.
`timescale 1ns / 1ps
`include "word_stream_utf8_hex_text_encoder_macros.svh"

module wsuhe_front import wsuhe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [FILL_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [UNIT_W-1:0] code_unit_i,
  input  logic              end_of_stream_i,
  output logic              push_o,
  output cmd_t              push_cmd_o,
  input  logic              full_i
);

  logic [FILL_W-1:0] max_chunk_q;
  logic              chunk_en_q;
  logic [FILL_W-1:0] fill_q, fill_d;

  logic              is_hex, is_three;
  logic [FILL_W:0]   size_ext;
  logic [FILL_W:0]   need;
  logic              pre_end;
  logic [FILL_W-1:0] base;
  logic [FILL_W:0]   sum;
  logic [FILL_W-1:0] sat;
  logic              accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  assign is_hex   = code_unit_i <= HEX_LIMIT;
  assign is_three = code_unit_i > UTF8_2_LIMIT;
  assign size_ext = is_three ? (FILL_W+1)'(3) : (FILL_W+1)'(2);

  assign need    = {1'b0, fill_q} + size_ext;
  assign pre_end = chunk_en_q && (need > {1'b0, max_chunk_q});
  assign base    = pre_end ? '0 : fill_q;
  assign sum     = {1'b0, base} + size_ext;
  assign sat     = sum[FILL_W] ? FILL_MAX : sum[FILL_W-1:0];
  assign fill_d  = end_of_stream_i ? '0 : sat;

  always_comb begin
    push_cmd_o          = '0;
    push_cmd_o.pre_end  = pre_end;
    push_cmd_o.post_end = end_of_stream_i;
    push_cmd_o.three    = is_three;
    push_cmd_o.b2       = UTF8_CONT | {2'b00, code_unit_i[5:0] & UTF8_PAYLOAD};
    if (is_hex) begin
      push_cmd_o.b0 = hex_char(code_unit_i[7:4]);
      push_cmd_o.b1 = hex_char(code_unit_i[3:0]);
    end else if (is_three) begin
      push_cmd_o.b0 = UTF8_LEAD3 | {4'h0, code_unit_i[15:12]};
      push_cmd_o.b1 = UTF8_CONT | {2'b00, code_unit_i[11:6]};
    end else begin
      push_cmd_o.b0 = UTF8_LEAD2 | {3'b000, code_unit_i[10:6]};
      push_cmd_o.b1 = UTF8_CONT | {2'b00, code_unit_i[5:0] & UTF8_PAYLOAD};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunk_q <= MAX_CHUNK_RST;
      chunk_en_q  <= 1'b0;
      fill_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_MAX_CHUNK_BYTES:  max_chunk_q <= cfg_wdata_i;
          REG_CHUNKING_ENABLED: chunk_en_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  `WSUHE_ASSERT_NEXT(a_eos_clears_fill, clk_i, rst_ni, accept && end_of_stream_i,
                     fill_q == '0, "chunk fill not cleared after end of stream")
  `WSUHE_ASSERT(a_no_end_when_off, clk_i, rst_ni, !(push_o && !chunk_en_q && push_cmd_o.pre_end),
                "chunk end requested while chunking is disabled")

endmodule

@@ hw/rtl/wsuhe_queue.sv @@
// Short command queue between front and back end.
// Depends on wsuhe_pkg for the command type.
`timescale 1ns / 1ps
`include "word_stream_utf8_hex_text_encoder_macros.svh"

module wsuhe_queue import wsuhe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o    = cnt_q == CW'(DEPTH);
  assign valid_o   = cnt_q != '0;
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  assign wr_ptr_d = !do_push ? wr_ptr_q :
                    (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
  assign rd_ptr_d = !do_pop ? rd_ptr_q :
                    (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `WSUHE_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(DEPTH), "queue count overflow")

endmodule

@@ hw/rtl/wsuhe_back.sv @@
// Back end: walks one command at a time and sends one result per transfer
// through a registered output stage. Depends on wsuhe_pkg.
`timescale 1ns / 1ps
`include "word_stream_utf8_hex_text_encoder_macros.svh"

module wsuhe_back import wsuhe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              cmd_valid_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o
);

  // pending bits: 0 leading chunk end, 1..3 text bytes, 4 trailing chunk end
  logic [4:0]        pend_q, pend_d;
  cmd_t              cur_q;
  logic [4:0]        low;
  logic [4:0]        rest;
  logic              advance, emit, load;
  kind_e             sel_kind;
  logic [BYTE_W-1:0] sel_byte;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;

  assign advance = !out_valid_q || out_ready_i;
  assign low     = pend_q & (~pend_q + 5'd1);
  assign rest    = pend_q & ~low;
  assign emit    = advance && (pend_q != '0);
  // fetch the next command when idle or when the last pending result leaves
  assign load    = (pend_q == '0) || (emit && (rest == '0));
  assign pop_o   = load && cmd_valid_i;

  always_comb begin
    sel_kind = KIND_TEXT;
    sel_byte = '0;
    priority if (low[0]) begin
      sel_kind = KIND_CHUNK_END;
    end else if (low[1]) begin
      sel_byte = cur_q.b0;
    end else if (low[2]) begin
      sel_byte = cur_q.b1;
    end else if (low[3]) begin
      sel_byte = cur_q.b2;
    end else begin
      sel_kind = KIND_CHUNK_END;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (load) begin
      pend_d = cmd_valid_i ?
               {cmd_i.post_end, cmd_i.three, 1'b1, 1'b1, cmd_i.pre_end} : '0;
    end else if (emit) begin
      pend_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (advance) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
    if (emit) begin
      out_kind_q <= sel_kind;
      out_byte_q <= sel_byte;
      out_last_q <= rest == '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = logic'(out_kind_q);
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `WSUHE_ASSERT(a_end_zero_byte, clk_i, rst_ni,
                !(out_valid_q && out_kind_q == KIND_CHUNK_END && out_byte_q != '0),
                "chunk end carries a nonzero byte")
  `WSUHE_ASSERT(a_text_always, clk_i, rst_ni, pend_q == '0 || pend_q[1] || pend_q[2] ||
                pend_q[4] || pend_q[3], "pending mask lost")
  `WSUHE_ASSERT_NEXT(a_load_has_text, clk_i, rst_ni, pop_o, pend_q[1] && pend_q[2],
                     "loaded command without its text bytes")

endmodule

@@ hw/rtl/word_stream_utf8_hex_text_encoder.sv @@
// Word stream text encoder: code units in, hex or UTF-8 text bytes and
// chunk ends out, one result per transfer.
//
// Input stream: s_axis_tdata carries one 16-bit code unit (first byte in
// bits 7:0), s_axis_tlast marks the final unit of a stream.
// Output stream: m_axis_tdata is the text byte (zero for a chunk end),
// m_axis_tuser is 0 for text and 1 for a chunk end, m_axis_tlast marks the
// final result of one input item. Each item gives 2 to 5 results.
// Config: cfg_we_i with cfg_idx_i 0 writes max_chunk_bytes, 1 writes
// chunking_enabled (bit 0); write only while the block is idle.
// The first result of an item passes the command queue, the back end's
// command register and the output register. The output sends one result
// per cycle while m_axis_tready is high and commands are queued, without
// gaps between items; the output port sets the rate.
// A stalled receiver holds the output register; the command queue fills
// and then s_axis_tready drops. Reset empties the queue and output,
// clears the chunk fill, sets max_chunk_bytes to 65535 and chunking off.
`timescale 1ns / 1ps

module word_stream_utf8_hex_text_encoder import wsuhe_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [FILL_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] code_unit
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] text_byte
  output logic              m_axis_tuser,   // [0] kind
  output logic              m_axis_tlast
);

  logic push, full, pop, cmd_valid;
  cmd_t push_cmd, pop_cmd;

  wsuhe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .code_unit_i    (s_axis_tdata),
    .end_of_stream_i(s_axis_tlast),
    .push_o         (push),
    .push_cmd_o     (push_cmd),
    .full_i         (full)
  );

  wsuhe_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .pop_cmd_o (pop_cmd),
    .valid_o   (cmd_valid)
  );

  wsuhe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pop_cmd),
    .cmd_valid_i(cmd_valid),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o (m_axis_tuser),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
